// ----- rtl/lpht_pkg.sv -----
// Shared constants, command codes and controller/datapath interface types
// for the linear-probing key/value table. No dependencies.
package lpht_pkg;

    localparam int SLOTS_DEF      = 256;
    localparam int KEY_BITS_DEF   = 32;
    localparam int VALUE_BITS_DEF = 32;

    // Port widths of the item fields.
    localparam int CMD_W    = 3;
    localparam int KEY_W    = 32;
    localparam int VAL_W    = 32;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 9;

    // Configuration port.
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 32;
    localparam int LIMIT_W    = 8;
    localparam logic [CFG_ADDR_W-1:0] REG_FILL_LIMIT = 2'd0;
    localparam logic [LIMIT_W-1:0]    FILL_LIMIT_RST = 8'd179;

    // Command codes.
    localparam logic [CMD_W-1:0] CMD_SET    = 3'd0;
    localparam logic [CMD_W-1:0] CMD_INSERT = 3'd1;
    localparam logic [CMD_W-1:0] CMD_UPDATE = 3'd2;
    localparam logic [CMD_W-1:0] CMD_GET    = 3'd3;
    localparam logic [CMD_W-1:0] CMD_CLEAR  = 3'd4;

    // Status codes.
    localparam logic [STATUS_W-1:0] ST_DONE     = 2'd0;
    localparam logic [STATUS_W-1:0] ST_PRESENCE = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL     = 2'd2;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load_item;  // capture the incoming beat
        logic addr_home;  // slot pointer to the key's home slot, probe count to zero
        logic addr_zero;  // slot pointer to the first slot
        logic rd_en;      // read the slot under the pointer
        logic step;       // advance pointer (wrapping) and probe count
        logic clr_write;  // mark the slot under the pointer empty
        logic commit;     // apply the command and load the result register
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic probe_stop; // slot read is empty or holds the key
        logic probe_last; // every slot has now been probed
        logic slot_last;  // pointer is on the last slot
        logic out_busy;   // result register still holds an untaken beat
    } t_dp_stat;

endpackage

// ----- rtl/lpht_ctrl.sv -----
// Sequencing controller for the linear-probing table: reset clearing pass,
// probe loop, clear sweep and result hand-off. Depends on lpht_pkg.
module lpht_ctrl (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    input  logic [lpht_pkg::CMD_W-1:0] i_command,
    input  lpht_pkg::t_dp_stat         i_stat,
    output logic                       o_in_ready,
    output lpht_pkg::t_dp_cmd          o_cmd
);

    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_READ,
        S_CHECK,
        S_CLEAR,
        S_FINISH
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   accept;

    assign o_in_ready = (r_state == S_IDLE);
    assign accept     = i_in_valid && o_in_ready;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_INIT: begin
                o_cmd.clr_write = 1'b1;
                o_cmd.step      = 1'b1;
                if (i_stat.slot_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (accept) begin
                    o_cmd.load_item = 1'b1;
                    if (i_command == lpht_pkg::CMD_CLEAR) begin
                        o_cmd.addr_zero = 1'b1;
                        n_state         = S_CLEAR;
                    end else if (i_command <= lpht_pkg::CMD_GET) begin
                        o_cmd.addr_home = 1'b1;
                        n_state         = S_READ;
                    end else begin
                        n_state = S_FINISH;
                    end
                end
            end
            S_READ: begin
                o_cmd.rd_en = 1'b1;
                n_state     = S_CHECK;
            end
            S_CHECK: begin
                if (i_stat.probe_stop || i_stat.probe_last) begin
                    n_state = S_FINISH;
                end else begin
                    o_cmd.step = 1'b1;
                    n_state    = S_READ;
                end
            end
            S_CLEAR: begin
                o_cmd.clr_write = 1'b1;
                o_cmd.step      = 1'b1;
                if (i_stat.slot_last) begin
                    n_state = S_FINISH;
                end
            end
            S_FINISH: begin
                if (!i_stat.out_busy) begin
                    o_cmd.commit = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ----- rtl/lpht_dp.sv -----
// Datapath of the linear-probing table: slot memory, item registers, probe
// pointer, entry count and result register. Depends on lpht_pkg.
module lpht_dp #(
    parameter int SLOTS      = lpht_pkg::SLOTS_DEF,
    parameter int KEY_BITS   = lpht_pkg::KEY_BITS_DEF,
    parameter int VALUE_BITS = lpht_pkg::VALUE_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  lpht_pkg::t_dp_cmd             i_cmd,
    output lpht_pkg::t_dp_stat            o_stat,
    input  logic [lpht_pkg::CMD_W-1:0]    i_command,
    input  logic [lpht_pkg::KEY_W-1:0]    i_key,
    input  logic [lpht_pkg::VAL_W-1:0]    i_value,
    input  logic [lpht_pkg::LIMIT_W-1:0]  i_fill_limit,
    input  logic                          i_out_ready,
    output logic                          o_out_valid,
    output logic                          o_found,
    output logic [lpht_pkg::VAL_W-1:0]    o_value_out,
    output logic [lpht_pkg::STATUS_W-1:0] o_status,
    output logic [lpht_pkg::COUNT_W-1:0]  o_entry_count
);

    localparam int ADDR_W = $clog2(SLOTS);
    localparam int CNT_W  = $clog2(SLOTS + 1);
    localparam int WORD_W = 1 + KEY_BITS + VALUE_BITS;
    localparam int LIM_W  = lpht_pkg::LIMIT_W;

    // Slot word: {used, key, value}.
    logic [WORD_W-1:0] r_mem [SLOTS];
    logic [WORD_W-1:0] r_rd_data;
    logic              mem_we;
    logic [WORD_W-1:0] mem_wdata;

    logic [lpht_pkg::CMD_W-1:0] r_command;
    logic [KEY_BITS-1:0]        r_key;
    logic [VALUE_BITS-1:0]      r_val;
    logic [ADDR_W-1:0]          r_addr;
    logic [ADDR_W-1:0]          r_probes;
    logic [CNT_W-1:0]           r_count;
    logic [CNT_W-1:0]           n_count;

    logic                            r_out_valid;
    logic                            r_found;
    logic [lpht_pkg::VAL_W-1:0]      r_value_out;
    logic [lpht_pkg::STATUS_W-1:0]   r_status;
    logic [lpht_pkg::COUNT_W-1:0]    r_out_count;

    logic [KEY_BITS+lpht_pkg::KEY_W-1:0]   key_ext;
    logic [VALUE_BITS+lpht_pkg::VAL_W-1:0] val_ext;
    logic [KEY_BITS-1:0]                   key_in;
    logic [VALUE_BITS-1:0]                 val_in;
    logic [KEY_BITS+ADDR_W-1:0]            key_wide;
    logic [ADDR_W-1:0]                     home_raw;
    logic [ADDR_W-1:0]                     home;
    logic [ADDR_W-1:0]                     addr_next;

    logic                  slot_used;
    logic [KEY_BITS-1:0]   slot_key;
    logic [VALUE_BITS-1:0] slot_val;
    logic                  key_match;
    logic                  is_lookup;
    logic                  hit;
    logic                  room;
    logic [CNT_W+LIM_W-1:0] count_x;
    logic [CNT_W+LIM_W-1:0] limit_x;
    logic [VALUE_BITS+lpht_pkg::VAL_W-1:0] vout_ext;
    logic [CNT_W+lpht_pkg::COUNT_W-1:0]    count_out_ext;

    logic                          res_found;
    logic [lpht_pkg::VAL_W-1:0]    res_value;
    logic [lpht_pkg::STATUS_W-1:0] res_status;
    logic                          wr_slot;

    // Input fields narrowed or widened to the table's key and value widths.
    assign key_ext = {{KEY_BITS{1'b0}}, i_key};
    assign val_ext = {{VALUE_BITS{1'b0}}, i_value};
    assign key_in  = key_ext[KEY_BITS-1:0];
    assign val_in  = val_ext[VALUE_BITS-1:0];

    // Home slot is the key's low ADDR_W bits modulo SLOTS; those bits are below twice SLOTS.
    assign key_wide = {{ADDR_W{1'b0}}, key_in};
    assign home_raw = key_wide[ADDR_W-1:0];
    assign home     = ({1'b0, home_raw} >= (ADDR_W + 1)'(SLOTS))
                    ? home_raw - ADDR_W'(SLOTS) : home_raw;

    assign addr_next = (r_addr == ADDR_W'(SLOTS - 1)) ? '0 : r_addr + 1'b1;

    assign slot_used = r_rd_data[WORD_W-1];
    assign slot_key  = r_rd_data[KEY_BITS+VALUE_BITS-1:VALUE_BITS];
    assign slot_val  = r_rd_data[VALUE_BITS-1:0];
    assign key_match = slot_used && (slot_key == r_key);

    assign o_stat.probe_stop = !slot_used || key_match;
    assign o_stat.probe_last = (r_probes == ADDR_W'(SLOTS - 1));
    assign o_stat.slot_last  = (r_addr == ADDR_W'(SLOTS - 1));
    assign o_stat.out_busy   = r_out_valid && !i_out_ready;

    assign is_lookup = (r_command <= lpht_pkg::CMD_GET);
    assign hit       = is_lookup && key_match;

    assign count_x = {{LIM_W{1'b0}}, r_count};
    assign limit_x = {{CNT_W{1'b0}}, i_fill_limit};
    assign room    = (count_x < limit_x) && (r_count < CNT_W'(SLOTS));

    assign vout_ext = {{lpht_pkg::VAL_W{1'b0}}, slot_val};

    // Outcome of the command once the probe has settled on a slot. A probe
    // that ran through every slot ends on a used slot with another key.
    always_comb begin
        res_found  = hit;
        res_value  = '0;
        res_status = lpht_pkg::ST_DONE;
        wr_slot    = 1'b0;
        n_count    = r_count;
        case (r_command)
            lpht_pkg::CMD_SET, lpht_pkg::CMD_INSERT: begin
                if (hit) begin
                    if (r_command == lpht_pkg::CMD_SET) begin
                        wr_slot = 1'b1;
                    end else begin
                        res_status = lpht_pkg::ST_PRESENCE;
                    end
                end else if (room && !slot_used) begin
                    wr_slot = 1'b1;
                    n_count = r_count + 1'b1;
                end else begin
                    res_status = lpht_pkg::ST_FULL;
                end
            end
            lpht_pkg::CMD_UPDATE: begin
                if (hit) begin
                    wr_slot = 1'b1;
                end else begin
                    res_status = lpht_pkg::ST_PRESENCE;
                end
            end
            lpht_pkg::CMD_GET: begin
                if (hit) begin
                    res_value = vout_ext[lpht_pkg::VAL_W-1:0];
                end
            end
            lpht_pkg::CMD_CLEAR: begin
                n_count = '0;
            end
            default: begin
                res_found = 1'b0;
            end
        endcase
    end

    assign count_out_ext = {{lpht_pkg::COUNT_W{1'b0}}, n_count};

    assign mem_we    = i_cmd.clr_write || (i_cmd.commit && wr_slot);
    assign mem_wdata = i_cmd.clr_write ? '0 : {1'b1, r_key, r_val};

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[r_addr] <= mem_wdata;
        end
        if (i_cmd.rd_en) begin
            r_rd_data <= r_mem[r_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_item) begin
            r_command <= i_command;
            r_key     <= key_in;
            r_val     <= val_in;
        end
        if (i_cmd.commit) begin
            r_found     <= res_found;
            r_value_out <= res_value;
            r_status    <= res_status;
            r_out_count <= count_out_ext[lpht_pkg::COUNT_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_addr      <= '0;
            r_probes    <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.addr_home) begin
                r_addr   <= home;
                r_probes <= '0;
            end else if (i_cmd.addr_zero) begin
                r_addr <= '0;
            end else if (i_cmd.step) begin
                r_addr   <= addr_next;
                r_probes <= r_probes + 1'b1;
            end
            if (i_cmd.commit) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_found       = r_found;
    assign o_value_out   = r_value_out;
    assign o_status      = r_status;
    assign o_entry_count = r_out_count;

endmodule

// ----- rtl/linear_probe_hash_table.sv -----
// One command is in flight at a time. A command's probe loop reads a slot and then checks
// it, slot by slot, on the single read port of the slot memory; clear sweeps every slot, and
// an unused command code goes straight to the result. A result not yet taken holds the next
// one back. After reset a clearing pass empties every slot before the first input beat is
// taken; configuration writes are taken throughout.
module linear_probe_hash_table #(
    parameter int SLOTS      = lpht_pkg::SLOTS_DEF,
    parameter int KEY_BITS   = lpht_pkg::KEY_BITS_DEF,
    parameter int VALUE_BITS = lpht_pkg::VALUE_BITS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  logic [lpht_pkg::CMD_W-1:0]         i_command,
    input  logic [lpht_pkg::KEY_W-1:0]         i_key,
    input  logic [lpht_pkg::VAL_W-1:0]         i_value,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output logic                               o_found,
    output logic [lpht_pkg::VAL_W-1:0]         o_value_out,
    output logic [lpht_pkg::STATUS_W-1:0]      o_status,
    output logic [lpht_pkg::COUNT_W-1:0]       o_entry_count,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [lpht_pkg::CFG_ADDR_W-1:0]    paddr,
    input  logic [lpht_pkg::CFG_DATA_W-1:0]    pwdata,
    output logic [lpht_pkg::CFG_DATA_W-1:0]    prdata,
    output logic                               pready
);

    lpht_pkg::t_dp_cmd  dp_cmd;
    lpht_pkg::t_dp_stat dp_stat;

    logic [lpht_pkg::LIMIT_W-1:0] r_fill_limit;
    logic                         cfg_write;

    // Configuration register.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && (paddr == lpht_pkg::REG_FILL_LIMIT);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill_limit <= lpht_pkg::FILL_LIMIT_RST;
        end else if (cfg_write) begin
            r_fill_limit <= pwdata[lpht_pkg::LIMIT_W-1:0];
        end
    end

    assign prdata = (paddr == lpht_pkg::REG_FILL_LIMIT)
                  ? {{(lpht_pkg::CFG_DATA_W - lpht_pkg::LIMIT_W){1'b0}}, r_fill_limit}
                  : '0;

    lpht_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_command  (i_command),
        .i_stat     (dp_stat),
        .o_in_ready (o_in_ready),
        .o_cmd      (dp_cmd)
    );

    lpht_dp #(
        .SLOTS      (SLOTS),
        .KEY_BITS   (KEY_BITS),
        .VALUE_BITS (VALUE_BITS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (dp_cmd),
        .o_stat        (dp_stat),
        .i_command     (i_command),
        .i_key         (i_key),
        .i_value       (i_value),
        .i_fill_limit  (r_fill_limit),
        .i_out_ready   (i_out_ready),
        .o_out_valid   (o_out_valid),
        .o_found       (o_found),
        .o_value_out   (o_value_out),
        .o_status      (o_status),
        .o_entry_count (o_entry_count)
    );

    // A refusal for want of room can only come from a key that was absent.
    a_full_not_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_status == lpht_pkg::ST_FULL)) |-> !o_found)
        else $error("full status reported for a key that was present");

    // Only a get that hits returns a stored value.
    a_value_needs_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_value_out != '0)) |-> (o_found && (o_status == lpht_pkg::ST_DONE)))
        else $error("value returned without a hit");

    // A taken beat drops ready in the next cycle, so one command is in progress at a time.
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("second beat taken while a command is in progress");

    // The reported entry count never exceeds the number of slots.
    a_count_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && ($past(dp_cmd.commit))) |->
            ((o_entry_count <= lpht_pkg::COUNT_W'(SLOTS)) || (SLOTS > 256)))
        else $error("entry count above the number of slots");

endmodule

// ----- verif/linear_probe_hash_table_tb.sv -----
// Self-checking testbench for the linear-probing key/value table: a directed table of beats,
// most with fixed expected results, then random command mixes across several fill limits
// checked against a local model. Depends on lpht_pkg and the linear_probe_hash_table RTL.
module linear_probe_hash_table_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_PER_PHASE = 95;
    localparam int PHASES           = 6;
    localparam int HOLD_OFF_CYCLES  = 300;
    localparam int KEY_POOL_SIZE    = 48;

    // Command codes the block treats as no operation.
    localparam logic [lpht_pkg::CMD_W-1:0] CMD_SPARE_5 = 3'd5;
    localparam logic [lpht_pkg::CMD_W-1:0] CMD_SPARE_6 = 3'd6;
    localparam logic [lpht_pkg::CMD_W-1:0] CMD_SPARE_7 = 3'd7;

    typedef struct packed {
        logic                          found;
        logic [lpht_pkg::VAL_W-1:0]    value_out;
        logic [lpht_pkg::STATUS_W-1:0] status;
        logic [lpht_pkg::COUNT_W-1:0]  entry_count;
    } t_lookup_result;

    typedef struct {
        logic [lpht_pkg::CMD_W-1:0] command;
        logic [lpht_pkg::KEY_W-1:0] key;
        logic [lpht_pkg::VAL_W-1:0] value;
        bit                         fixed;
        t_lookup_result             want;
    } t_stim_row;

    logic                            i_clk = 1'b0;
    logic                            i_rst_n = 1'b0;
    logic                            i_in_valid = 1'b0;
    logic                            o_in_ready;
    logic [lpht_pkg::CMD_W-1:0]      i_command = lpht_pkg::CMD_GET;
    logic [lpht_pkg::KEY_W-1:0]      i_key = '0;
    logic [lpht_pkg::VAL_W-1:0]      i_value = '0;
    logic                            o_out_valid;
    logic                            i_out_ready = 1'b0;
    logic                            o_found;
    logic [lpht_pkg::VAL_W-1:0]      o_value_out;
    logic [lpht_pkg::STATUS_W-1:0]   o_status;
    logic [lpht_pkg::COUNT_W-1:0]    o_entry_count;
    logic                            psel = 1'b0;
    logic                            penable = 1'b0;
    logic                            pwrite = 1'b0;
    logic [lpht_pkg::CFG_ADDR_W-1:0] paddr = lpht_pkg::REG_FILL_LIMIT;
    logic [lpht_pkg::CFG_DATA_W-1:0] pwdata = '0;
    logic [lpht_pkg::CFG_DATA_W-1:0] prdata;
    logic                            pready;

    // Table model: what the block should hold, keyed by key.
    logic [lpht_pkg::VAL_W-1:0]   held_value [logic [lpht_pkg::KEY_W-1:0]];
    logic [lpht_pkg::KEY_W-1:0]   live_keys [$];
    logic [lpht_pkg::KEY_W-1:0]   key_pool [KEY_POOL_SIZE];
    int unsigned                  held_count = 0;
    logic [lpht_pkg::LIMIT_W-1:0] limit_shadow = lpht_pkg::FILL_LIMIT_RST;

    t_lookup_result expected_results [$];
    t_stim_row      directed_rows [$];

    int unsigned in_idle_pct = 9;
    int unsigned out_idle_pct = 45;
    int unsigned hold_ask = 0;
    int unsigned hold_done = 0;
    int unsigned hold_left = 0;
    int unsigned err_count = 0;
    int unsigned results_seen = 0;

    linear_probe_hash_table u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_command     (i_command),
        .i_key         (i_key),
        .i_value       (i_value),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_found       (o_found),
        .o_value_out   (o_value_out),
        .o_status      (o_status),
        .o_entry_count (o_entry_count),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #30ms;
        $display("linear_probe_hash_table regression: fail");
        $finish;
    end

    task automatic report_mismatch(input string what);
        $display("MISMATCH at %0t: %s", $realtime, what);
        err_count++;
    endtask

    // Applies one command to the model and returns the result the block owes for it.
    // With the fill limit below SLOTS an empty slot always remains, so the outcome
    // does not depend on the hash or on probe order.
    function automatic t_lookup_result apply_table_op(
        input logic [lpht_pkg::CMD_W-1:0] cmd,
        input logic [lpht_pkg::KEY_W-1:0] key,
        input logic [lpht_pkg::VAL_W-1:0] val);
        t_lookup_result r;
        logic hit;
        r = '0;
        hit = 1'b0;
        if (cmd <= lpht_pkg::CMD_GET) hit = (held_value.exists(key) != 0);
        case (cmd)
            lpht_pkg::CMD_SET, lpht_pkg::CMD_INSERT: begin
                if (hit) begin
                    if (cmd == lpht_pkg::CMD_SET) held_value[key] = val;
                    else r.status = lpht_pkg::ST_PRESENCE;
                end else if (held_count >= limit_shadow ||
                             held_count >= lpht_pkg::SLOTS_DEF) begin
                    r.status = lpht_pkg::ST_FULL;
                end else begin
                    held_value[key] = val;
                    held_count++;
                    live_keys.push_back(key);
                end
            end
            lpht_pkg::CMD_UPDATE: begin
                if (hit) held_value[key] = val;
                else r.status = lpht_pkg::ST_PRESENCE;
            end
            lpht_pkg::CMD_GET: begin
                if (hit) r.value_out = held_value[key];
            end
            lpht_pkg::CMD_CLEAR: begin
                held_value.delete();
                live_keys.delete();
                held_count = 0;
            end
            default: ;
        endcase
        r.found = hit;
        r.entry_count = lpht_pkg::COUNT_W'(held_count);
        return r;
    endfunction

    function automatic void add_row(input logic [lpht_pkg::CMD_W-1:0] cmd,
                                    input logic [lpht_pkg::KEY_W-1:0] key,
                                    input logic [lpht_pkg::VAL_W-1:0] val, input bit fixed,
                                    input logic f, input logic [lpht_pkg::VAL_W-1:0] v,
                                    input logic [lpht_pkg::STATUS_W-1:0] s,
                                    input int unsigned c);
        t_stim_row row;
        row.command = cmd;
        row.key = key;
        row.value = val;
        row.fixed = fixed;
        row.want = '{f, v, s, lpht_pkg::COUNT_W'(c)};
        directed_rows.push_back(row);
    endfunction

    // Offers one beat, holding it until taken, then records what it should produce.
    // Valid is only lowered when a gap precedes the beat, so back-to-back beats keep it high.
    task automatic send_beat(input logic [lpht_pkg::CMD_W-1:0] cmd,
                             input logic [lpht_pkg::KEY_W-1:0] key,
                             input logic [lpht_pkg::VAL_W-1:0] val, input bit fixed,
                             input t_lookup_result typed);
        int unsigned gap;
        t_lookup_result predicted;
        gap = 0;
        while ($urandom_range(0, 99) < in_idle_pct) gap++;
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_command <= cmd;
        i_key <= key;
        i_value <= val;
        do @(posedge i_clk); while (!(i_in_valid && o_in_ready));
        predicted = apply_table_op(cmd, key, val);
        expected_results.push_back(fixed ? typed : predicted);
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (expected_results.size() != 0);
    endtask

    // Reads back the current limit, writes the new one and reads it again.
    task automatic program_fill_limit(input logic [lpht_pkg::LIMIT_W-1:0] lim);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= lpht_pkg::REG_FILL_LIMIT;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata !== lpht_pkg::CFG_DATA_W'(limit_shadow))
            report_mismatch($sformatf("fill_limit read %0h, expected %0h", prdata, limit_shadow));
        penable <= 1'b0;
        pwrite <= 1'b1;
        pwdata <= lpht_pkg::CFG_DATA_W'(lim);
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        limit_shadow = lim;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata !== lpht_pkg::CFG_DATA_W'(limit_shadow))
            report_mismatch($sformatf("fill_limit read %0h, expected %0h", prdata, limit_shadow));
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    function automatic logic [lpht_pkg::KEY_W-1:0] pick_key();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 45) return key_pool[$urandom_range(0, KEY_POOL_SIZE - 1)];
        if (r < 85 && live_keys.size() != 0)
            return live_keys[$urandom_range(0, live_keys.size() - 1)];
        return $urandom;
    endfunction

    task automatic random_item();
        logic [lpht_pkg::CMD_W-1:0] cmd;
        logic [lpht_pkg::VAL_W-1:0] val;
        logic [lpht_pkg::CMD_W-1:0] spare [3];
        int unsigned r;
        spare = '{CMD_SPARE_5, CMD_SPARE_6, CMD_SPARE_7};
        r = $urandom_range(0, 99);
        if (r < 26) cmd = lpht_pkg::CMD_SET;
        else if (r < 42) cmd = lpht_pkg::CMD_INSERT;
        else if (r < 56) cmd = lpht_pkg::CMD_UPDATE;
        else if (r < 92) cmd = lpht_pkg::CMD_GET;
        else if (r < 95) cmd = lpht_pkg::CMD_CLEAR;
        else cmd = spare[$urandom_range(0, 2)];
        r = $urandom_range(0, 99);
        if (r < 5) val = '0;
        else if (r < 10) val = '1;
        else val = $urandom;
        send_beat(cmd, pick_key(), val, 1'b0, '0);
    endtask

    // Empties the table, then stores fresh keys until a few beyond the limit are refused.
    // Half the keys share a handful of low bytes, which builds long probe runs.
    task automatic fill_table();
        logic [lpht_pkg::KEY_W-1:0] key;
        int unsigned burst;
        send_beat(lpht_pkg::CMD_CLEAR, $urandom, $urandom, 1'b0, '0);
        burst = int'(limit_shadow) + 4;
        repeat (burst) begin
            key = $urandom;
            if ($urandom_range(0, 1) != 0) key[7:0] = 8'($urandom_range(0, 15));
            send_beat(($urandom_range(0, 3) == 0) ? lpht_pkg::CMD_INSERT : lpht_pkg::CMD_SET,
                      key, $urandom, 1'b0, '0);
        end
    endtask

    // Result side: checks each taken beat and draws the ready pattern, including the
    // long hold-off that backs the block up into its input.
    always @(posedge i_clk) begin : result_check
        t_lookup_result want;
        if (o_out_valid && i_out_ready) begin
            results_seen++;
            if (expected_results.size() == 0) begin
                report_mismatch($sformatf("result beat %0d with nothing pending", results_seen));
            end else begin
                want = expected_results.pop_front();
                if (o_found !== want.found)
                    report_mismatch($sformatf("beat %0d found %b, expected %b",
                                              results_seen, o_found, want.found));
                if (o_value_out !== want.value_out)
                    report_mismatch($sformatf("beat %0d value_out %0h, expected %0h",
                                              results_seen, o_value_out, want.value_out));
                if (o_status !== want.status)
                    report_mismatch($sformatf("beat %0d status %0d, expected %0d",
                                              results_seen, o_status, want.status));
                if (o_entry_count !== want.entry_count)
                    report_mismatch($sformatf("beat %0d entry_count %0d, expected %0d",
                                              results_seen, o_entry_count, want.entry_count));
            end
        end
        if (hold_left != 0) begin
            hold_left--;
            i_out_ready <= 1'b0;
        end else if (hold_ask != hold_done) begin
            hold_done = hold_ask;
            hold_left = HOLD_OFF_CYCLES;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(0, 99) >= out_idle_pct);
        end
    end

    initial begin
        logic [lpht_pkg::LIMIT_W-1:0] lim;
        for (int i = 0; i < KEY_POOL_SIZE; i++) begin
            key_pool[i] = $urandom;
            if (i < 16) key_pool[i][7:0] = 8'h3C;
        end
        key_pool[0] = '0;
        key_pool[1] = '1;

        // Directed beats run with a limit of three so that refusal for fullness comes early.
        add_row(lpht_pkg::CMD_GET,    32'h0000_0000, 32'h0000_0000, 1'b1,
                1'b0, 32'h0, lpht_pkg::ST_DONE, 0);
        add_row(lpht_pkg::CMD_UPDATE, 32'hFFFF_FFFF, 32'h0000_0001, 1'b1,
                1'b0, 32'h0, lpht_pkg::ST_PRESENCE, 0);
        add_row(lpht_pkg::CMD_SET,    32'h0000_0000, 32'hFFFF_FFFF, 1'b1,
                1'b0, 32'h0, lpht_pkg::ST_DONE, 1);
        add_row(lpht_pkg::CMD_GET,    32'h0000_0000, 32'h0000_0000, 1'b1,
                1'b1, 32'hFFFF_FFFF, lpht_pkg::ST_DONE, 1);
        add_row(lpht_pkg::CMD_INSERT, 32'h0000_0000, 32'h0000_0005, 1'b1,
                1'b1, 32'h0, lpht_pkg::ST_PRESENCE, 1);
        add_row(lpht_pkg::CMD_INSERT, 32'hFFFF_FFFF, 32'h0000_0000, 1'b1,
                1'b0, 32'h0, lpht_pkg::ST_DONE, 2);
        add_row(lpht_pkg::CMD_UPDATE, 32'hFFFF_FFFF, 32'hA5A5_A5A5, 1'b1,
                1'b1, 32'h0, lpht_pkg::ST_DONE, 2);
        add_row(lpht_pkg::CMD_GET,    32'hFFFF_FFFF, 32'h0000_0000, 1'b1,
                1'b1, 32'hA5A5_A5A5, lpht_pkg::ST_DONE, 2);
        add_row(lpht_pkg::CMD_SET,    32'h0000_0100, 32'h1234_5678, 1'b1,
                1'b0, 32'h0, lpht_pkg::ST_DONE, 3);
        add_row(lpht_pkg::CMD_SET,    32'h0000_0200, 32'h0000_0001, 1'b1,
                1'b0, 32'h0, lpht_pkg::ST_FULL, 3);
        add_row(lpht_pkg::CMD_INSERT, 32'h0000_0200, 32'h0000_0002, 1'b1,
                1'b0, 32'h0, lpht_pkg::ST_FULL, 3);
        add_row(lpht_pkg::CMD_UPDATE, 32'h0000_0200, 32'h0000_0003, 1'b1,
                1'b0, 32'h0, lpht_pkg::ST_PRESENCE, 3);
        add_row(lpht_pkg::CMD_SET,    32'h0000_0100, 32'h0000_0000, 1'b1,
                1'b1, 32'h0, lpht_pkg::ST_DONE, 3);
        add_row(lpht_pkg::CMD_GET,    32'h0000_0100, 32'h0000_0000, 1'b1,
                1'b1, 32'h0, lpht_pkg::ST_DONE, 3);
        add_row(lpht_pkg::CMD_GET,    32'h0000_0200, 32'h0000_0000, 1'b1,
                1'b0, 32'h0, lpht_pkg::ST_DONE, 3);
        add_row(CMD_SPARE_5,          32'h0000_0000, 32'hFFFF_FFFF, 1'b1,
                1'b0, 32'h0, lpht_pkg::ST_DONE, 3);
        add_row(CMD_SPARE_6,          32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1,
                1'b0, 32'h0, lpht_pkg::ST_DONE, 3);
        add_row(CMD_SPARE_7,          32'h0000_0100, 32'h0000_0000, 1'b1,
                1'b0, 32'h0, lpht_pkg::ST_DONE, 3);
        add_row(lpht_pkg::CMD_CLEAR,  32'h0000_0100, 32'h0000_0000, 1'b1,
                1'b0, 32'h0, lpht_pkg::ST_DONE, 0);
        add_row(lpht_pkg::CMD_GET,    32'h0000_0100, 32'h0000_0000, 1'b1,
                1'b0, 32'h0, lpht_pkg::ST_DONE, 0);
        add_row(lpht_pkg::CMD_SET,    32'h8000_0000, 32'h7FFF_FFFF, 1'b0,
                1'b0, 32'h0, lpht_pkg::ST_DONE, 0);
        add_row(lpht_pkg::CMD_GET,    32'h8000_0000, 32'h0000_0000, 1'b0,
                1'b0, 32'h0, lpht_pkg::ST_DONE, 0);
        add_row(lpht_pkg::CMD_SET,    32'h8000_0000, 32'h8000_0001, 1'b0,
                1'b0, 32'h0, lpht_pkg::ST_DONE, 0);
        add_row(lpht_pkg::CMD_GET,    32'h8000_0000, 32'h0000_0000, 1'b0,
                1'b0, 32'h0, lpht_pkg::ST_DONE, 0);

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        program_fill_limit(8'd3);
        foreach (directed_rows[i])
            send_beat(directed_rows[i].command, directed_rows[i].key, directed_rows[i].value,
                      directed_rows[i].fixed, directed_rows[i].want);

        for (int ph = 0; ph < PHASES; ph++) begin
            wait_drained();
            case (ph)
                0:       lim = 8'd1;
                1:       lim = 8'd255;
                2:       lim = 8'd0;
                3:       lim = lpht_pkg::LIMIT_W'($urandom_range(1, 254));
                4:       lim = lpht_pkg::FILL_LIMIT_RST;
                default: lim = lpht_pkg::LIMIT_W'($urandom_range(1, 255));
            endcase
            program_fill_limit(lim);
            in_idle_pct  = (ph < 2) ? 9 : (ph < 4) ? 45 : 0;
            out_idle_pct = (ph < 2) ? 45 : (ph < 4) ? 9 : 0;
            if (ph == 1 || ph == 4) begin
                hold_ask++;
                fill_table();
            end
            repeat (RANDOM_PER_PHASE) begin
                random_item();
                if ($urandom_range(0, 49) == 0) wait_drained();
            end
        end

        wait_drained();
        repeat (lpht_pkg::SLOTS_DEF + 8) @(posedge i_clk);
        if (err_count == 0)
            $display("linear_probe_hash_table regression: pass");
        else
            $display("linear_probe_hash_table regression: fail");
        $finish;
    end

endmodule
